@@ hdl/skcl_pkg.sv @@
// shared types and constants for the scale key light colour block
`default_nettype none
package skcl_pkg;

  // scale word layout: 4-bit entry count then twelve 5-bit entries
  localparam int SCALE_SLOTS = 12;
  localparam int CNT_W       = 4;
  localparam int ENT_W       = 5;

  // signed width of the unwrapped note sum
  localparam int NOTE_W = 13;

  // remainder unit dividend width
  localparam int DIV_W = 12;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PLAYING_TONIC   = 3'd0,
    REG_BASE_NOTE       = 3'd1,
    REG_OCTAVE_SPAN     = 3'd2,
    REG_REF_TONIC       = 3'd3,
    REG_LIGHT_MODE      = 3'd4,
    REG_PLAYING_SCALE   = 3'd5,
    REG_REFERENCE_SCALE = 3'd6
  } cfg_reg_t;

  // key colours
  typedef enum logic [1:0] {
    COL_OFF      = 2'd0,
    COL_ACTIVE   = 2'd1,
    COL_INACTIVE = 2'd2
  } colour_t;

  // reset values of the configuration registers
  localparam logic [3:0]  RST_PLAYING_TONIC = 4'd0;
  localparam logic [5:0]  RST_BASE_NOTE     = 6'd0;
  localparam logic [4:0]  RST_OCTAVE_SPAN   = 5'd12;
  localparam logic [4:0]  RST_REF_TONIC     = 5'd0;
  localparam logic [1:0]  RST_LIGHT_MODE    = 2'd1;
  localparam logic [63:0] RST_PLAYING_SCALE = 64'd193930527751;
  localparam logic [63:0] RST_REF_SCALE     = 64'd0;

  // request to the shared remainder unit
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [4:0]       divisor;
    logic [3:0]       nbits;
  } rem_req_t;

  // answer from the shared remainder unit
  typedef struct packed {
    logic       done;
    logic [4:0] rem;
  } rem_rsp_t;

endpackage
`default_nettype wire

@@ hdl/scale_key_light_colour.sv @@
// top level: key colour sequencer, configuration registers and output stage
//
// One input word describes one course and yields one output word per row.
// All wrap-around arithmetic runs through one shared remainder unit that
// resolves one dividend bit per cycle, and the block takes no new course
// while it works. A course first wraps each reference note (0 to 12 of
// them, set by the reference entry count), then divides for the scale start
// position, then for each key wraps the note and hands the word to the
// output register, waiting while that register is still held by the
// receiver. A negative scale offset skips the start position division.
// With a zero octave span the wraps are skipped. An empty playing scale or
// a zero-length course finishes in the accept cycle with no words. The
// output register lets the next course be accepted while the last key word
// still waits.
`default_nettype none
module scale_key_light_colour
  import skcl_pkg::*;
#(
  parameter int MAX_ROWS      = 32,
  parameter int SCALE_ENTRIES = 12,
  parameter int MAX_COURSES   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: course_length[5:0], scale_offset_step[12:6],
  //           semitone_offset_step[19:13], zero pad[23:20]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  // in_tuser: first_course[0]
  input  wire logic        in_tuser,
  // out_tdata: course_number[3:0], row_number[9:4], colour[11:10], zero pad[15:12]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  // out_tlast: last_in_course
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int LEN_W = $clog2(MAX_ROWS + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_REF   = 8'b0000_0010,
    S_RWAIT = 8'b0000_0100,
    S_POS   = 8'b0000_1000,
    S_PWAIT = 8'b0001_0000,
    S_NOTE  = 8'b0010_0000,
    S_NWAIT = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  // configuration registers
  logic [3:0]  playing_tonic_r;
  logic [5:0]  base_note_r;
  logic [4:0]  octave_span_r;
  logic [4:0]  ref_tonic_r;
  logic [1:0]  light_mode_r;
  logic [63:0] playing_scale_r;
  logic [63:0] reference_scale_r;

  // sequencer and running state
  state_t                   state_r, state_nxt;
  logic [3:0]               course_r, course_nxt;
  logic [11:0]              so_tot_r, so_tot_nxt;
  logic [11:0]              st_tot_r, st_tot_nxt;
  logic [3:0]               pos_r, pos_nxt;
  logic [CNT_W-1:0]         size_r, size_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [LEN_W-1:0]         row_r, row_nxt;
  logic [3:0]               ref_k_r, ref_k_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [NOTE_W-1:0] note_r, note_nxt;
  logic [5:0]               ref_note_r [SCALE_SLOTS];
  logic [5:0]               ref_note_nxt [SCALE_SLOTS];

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_course_r, out_course_nxt;
  logic [5:0] out_row_r, out_row_nxt;
  logic [1:0] out_colour_r, out_colour_nxt;
  logic       out_last_r, out_last_nxt;

  // combinational helpers
  logic [ENT_W-1:0]         play_ent [SCALE_SLOTS];
  logic [ENT_W-1:0]         ref_ent  [SCALE_SLOTS];
  logic [CNT_W-1:0]         play_cnt, ref_cnt;
  logic                     in_acc;
  logic [5:0]               in_len;
  logic [6:0]               in_so, in_st;
  logic                     in_first;
  logic [11:0]              so_base, st_base;
  logic [4:0]               course_inc;
  logic [6:0]               len_clamp;
  logic signed [NOTE_W-1:0] note_sum;
  logic [DIV_W-1:0]         note_mag;
  logic [5:0]               ref_sum;
  logic [LEN_W-1:0]         row_inc;
  logic [6:0]               row_wide;
  logic                     out_free;
  rem_req_t                 rem_req;
  rem_rsp_t                 rem_rsp;
  colour_t                  key_colour;

  assign in_len   = in_tdata[5:0];
  assign in_so    = in_tdata[12:6];
  assign in_st    = in_tdata[19:13];
  assign in_first = in_tuser;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // unpack scale words into entries
  always_comb begin
    for (int k = 0; k < SCALE_SLOTS; k++) begin
      play_ent[k] = playing_scale_r[CNT_W + ENT_W*k +: ENT_W];
      ref_ent[k]  = reference_scale_r[CNT_W + ENT_W*k +: ENT_W];
    end
  end

  // entry counts saturate at the scale size
  assign play_cnt = (playing_scale_r[CNT_W-1:0] > CNT_W'(SCALE_ENTRIES))
                    ? CNT_W'(SCALE_ENTRIES) : playing_scale_r[CNT_W-1:0];
  assign ref_cnt  = (reference_scale_r[CNT_W-1:0] > CNT_W'(SCALE_ENTRIES))
                    ? CNT_W'(SCALE_ENTRIES) : reference_scale_r[CNT_W-1:0];

  // course accept arithmetic
  assign so_base    = in_first ? 12'd0 : so_tot_r;
  assign st_base    = in_first ? 12'd0 : st_tot_r;
  assign course_inc = (in_first ? 5'd0 : {1'b0, course_r}) + 5'd1;
  assign len_clamp  = ({1'b0, in_len} > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : {1'b0, in_len};

  // unwrapped note of the current key
  assign note_sum = $signed({8'd0, play_ent[pos_r]})
                  + $signed({9'd0, playing_tonic_r})
                  + NOTE_W'($signed(base_note_r))
                  + NOTE_W'($signed(st_tot_r));
  assign note_mag = note_sum[NOTE_W-1] ? DIV_W'(-note_sum) : DIV_W'(note_sum);

  assign ref_sum  = {1'b0, ref_ent[ref_k_r]} + {1'b0, ref_tonic_r};
  assign row_inc  = row_r + LEN_W'(1);
  assign row_wide = 7'(row_inc);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    course_nxt     = course_r;
    so_tot_nxt     = so_tot_r;
    st_tot_nxt     = st_tot_r;
    pos_nxt        = pos_r;
    size_nxt       = size_r;
    len_nxt        = len_r;
    row_nxt        = row_r;
    ref_k_nxt      = ref_k_r;
    neg_nxt        = neg_r;
    note_nxt       = note_r;
    ref_note_nxt   = ref_note_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_course_nxt = out_course_r;
    out_row_nxt    = out_row_r;
    out_colour_nxt = out_colour_r;
    out_last_nxt   = out_last_r;
    rem_req        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          so_tot_nxt = so_base + {{5{in_so[6]}}, in_so};
          st_tot_nxt = st_base + {{5{in_st[6]}}, in_st};
          course_nxt = (course_inc > 5'(MAX_COURSES)) ? 4'(MAX_COURSES)
                                                      : course_inc[3:0];
          size_nxt   = play_cnt;
          len_nxt    = LEN_W'(len_clamp);
          row_nxt    = '0;
          ref_k_nxt  = 4'd0;
          if (play_cnt != '0 && len_clamp != 7'd0) begin
            state_nxt = S_REF;
          end
        end
      end
      S_REF: begin
        if (ref_k_r >= ref_cnt) begin
          state_nxt = S_POS;
        end else if (octave_span_r == 5'd0) begin
          ref_note_nxt[ref_k_r] = ref_sum;
          ref_k_nxt = ref_k_r + 4'd1;
        end else begin
          rem_req.start    = 1'b1;
          rem_req.dividend = DIV_W'(ref_sum);
          rem_req.divisor  = octave_span_r;
          rem_req.nbits    = 4'd6;
          state_nxt        = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (rem_rsp.done) begin
          ref_note_nxt[ref_k_r] = {1'b0, rem_rsp.rem};
          ref_k_nxt = ref_k_r + 4'd1;
          state_nxt = S_REF;
        end
      end
      S_POS: begin
        if (so_tot_r[11]) begin
          pos_nxt   = 4'd0;
          state_nxt = S_NOTE;
        end else begin
          rem_req.start    = 1'b1;
          rem_req.dividend = so_tot_r;
          rem_req.divisor  = {1'b0, size_r};
          rem_req.nbits    = 4'(DIV_W);
          state_nxt        = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (rem_rsp.done) begin
          pos_nxt   = rem_rsp.rem[3:0];
          state_nxt = S_NOTE;
        end
      end
      S_NOTE: begin
        if (octave_span_r == 5'd0) begin
          note_nxt  = note_sum;
          state_nxt = S_EMIT;
        end else begin
          neg_nxt          = note_sum[NOTE_W-1];
          rem_req.start    = 1'b1;
          rem_req.dividend = note_mag;
          rem_req.divisor  = octave_span_r;
          rem_req.nbits    = 4'(DIV_W);
          state_nxt        = S_NWAIT;
        end
      end
      S_NWAIT: begin
        if (rem_rsp.done) begin
          note_nxt  = neg_r ? -$signed({8'd0, rem_rsp.rem})
                            : $signed({8'd0, rem_rsp.rem});
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_course_nxt = course_r;
          out_row_nxt    = row_wide[5:0];
          out_colour_nxt = key_colour;
          out_last_nxt   = (row_inc == len_r);
          row_nxt        = row_inc;
          pos_nxt        = ((pos_r + 4'd1) >= size_r) ? 4'd0 : pos_r + 4'd1;
          state_nxt      = (row_inc == len_r) ? S_IDLE : S_NOTE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_tonic_r   <= RST_PLAYING_TONIC;
      base_note_r       <= RST_BASE_NOTE;
      octave_span_r     <= RST_OCTAVE_SPAN;
      ref_tonic_r       <= RST_REF_TONIC;
      light_mode_r      <= RST_LIGHT_MODE;
      playing_scale_r   <= RST_PLAYING_SCALE;
      reference_scale_r <= RST_REF_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PLAYING_TONIC:   playing_tonic_r   <= cfg_data[3:0];
        REG_BASE_NOTE:       base_note_r       <= cfg_data[5:0];
        REG_OCTAVE_SPAN:     octave_span_r     <= cfg_data[4:0];
        REG_REF_TONIC:       ref_tonic_r       <= cfg_data[4:0];
        REG_LIGHT_MODE:      light_mode_r      <= cfg_data[1:0];
        REG_PLAYING_SCALE:   playing_scale_r   <= cfg_data;
        REG_REFERENCE_SCALE: reference_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      course_r    <= 4'd0;
      so_tot_r    <= 12'd0;
      st_tot_r    <= 12'd0;
      pos_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      course_r    <= course_nxt;
      so_tot_r    <= so_tot_nxt;
      st_tot_r    <= st_tot_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    size_r       <= size_nxt;
    len_r        <= len_nxt;
    row_r        <= row_nxt;
    ref_k_r      <= ref_k_nxt;
    neg_r        <= neg_nxt;
    note_r       <= note_nxt;
    ref_note_r   <= ref_note_nxt;
    out_course_r <= out_course_nxt;
    out_row_r    <= out_row_nxt;
    out_colour_r <= out_colour_nxt;
    out_last_r   <= out_last_nxt;
  end

  skcl_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  skcl_colour u_colour (
    .note          (note_r),
    .ref_note      (ref_note_r),
    .ref_cnt       (ref_cnt),
    .playing_tonic (playing_tonic_r),
    .ref_tonic     (ref_tonic_r),
    .light_mode    (light_mode_r),
    .colour        (key_colour)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_colour_r, out_row_r, out_course_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

@@ hdl/skcl_rem_unit.sv @@
// shared restoring remainder unit, one dividend bit per cycle
`default_nettype none
module skcl_rem_unit
  import skcl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rem_req_t req,
  output rem_rsp_t      rsp
);

  logic [DIV_W-1:0] shreg_r, shreg_nxt;
  logic [4:0]       rem_r, rem_nxt;
  logic [4:0]       div_r, div_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [5:0]       trial;
  logic [3:0]       shamt;

  assign trial = {rem_r, shreg_r[DIV_W-1]};
  assign shamt = 4'(DIV_W) - req.nbits;

  // one compare and subtract per cycle
  always_comb begin
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      shreg_nxt = req.dividend << shamt;
      rem_nxt   = 5'd0;
      div_nxt   = req.divisor;
      cnt_nxt   = req.nbits;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = 5'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[4:0];
      end
      shreg_nxt = shreg_r << 1;
      cnt_nxt   = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

@@ hdl/skcl_colour.sv @@
// colour decision for one key from its wrapped note
`default_nettype none
module skcl_colour
  import skcl_pkg::*;
(
  input  wire logic signed [NOTE_W-1:0] note,
  input  wire logic [5:0]               ref_note [SCALE_SLOTS],
  input  wire logic [CNT_W-1:0]         ref_cnt,
  input  wire logic [3:0]               playing_tonic,
  input  wire logic [4:0]               ref_tonic,
  input  wire logic [1:0]               light_mode,
  output colour_t                       colour
);

  logic                     missing_ref;
  logic                     in_scale;
  logic                     tonic_key;
  logic signed [NOTE_W-1:0] tonic_note;

  assign missing_ref = (ref_cnt == '0);
  assign tonic_note  = missing_ref ? $signed({9'd0, playing_tonic})
                                   : $signed({8'd0, ref_tonic});
  assign tonic_key   = light_mode[0] && (note == tonic_note);

  // match against every valid reference note at once
  always_comb begin
    in_scale = 1'b0;
    for (int k = 0; k < SCALE_SLOTS; k++) begin
      if ((4'(k) < ref_cnt) && (note == $signed({7'd0, ref_note[k]}))) begin
        in_scale = 1'b1;
      end
    end
  end

  // tonic first, then off without a reference scale, then reference membership with optional inversion
  always_comb begin
    if (tonic_key) begin
      colour = light_mode[1] ? COL_ACTIVE : COL_INACTIVE;
    end else if (missing_ref) begin
      colour = COL_OFF;
    end else if (!light_mode[1]) begin
      colour = in_scale ? COL_ACTIVE : COL_OFF;
    end else begin
      colour = in_scale ? COL_OFF : COL_INACTIVE;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench for the scale key light colour block: predicts and checks every key word
module testbench;
  import skcl_pkg::*;

  localparam int MAX_ROWS        = 32;
  localparam int SCALE_ENTRIES   = 12;
  localparam int MAX_COURSES     = 8;
  localparam logic [2:0] REG_UNUSED = 3'd7;  // index past the register list
  localparam int SETTLE_CYCLES   = 640;      // worst course: 12 ref notes and 32 keys
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int RUN_LIMIT       = 25_000_000;

  typedef struct packed {
    logic [3:0] course;
    logic [5:0] row;
    colour_t    colour;
    logic       last;
  } key_word_t;

  typedef struct packed {
    logic [3:0]  tonic;
    logic [5:0]  base;
    logic [4:0]  span;
    logic [4:0]  ref_tonic;
    logic [1:0]  mode;
    logic [63:0] play_scale;
    logic [63:0] ref_scale;
  } light_setup_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // predictor copy of the registers and the running state
  logic [3:0]  cur_tonic;
  logic [5:0]  cur_base;
  logic [4:0]  cur_span;
  logic [4:0]  cur_ref_tonic;
  logic [1:0]  cur_mode;
  logic [63:0] cur_play;
  logic [63:0] cur_ref;
  logic [3:0]  courses_seen;
  logic [11:0] scale_total;
  logic [11:0] semitone_total;

  key_word_t pending_keys[$];

  int mismatches       = 0;
  int words_checked    = 0;
  int courses_accepted = 0;
  int setups_loaded    = 0;

  // sender burst state
  int burst_left = 0;

  // receiver stall pattern and long hold-off request
  int hold_request = 0;
  int hold_serial  = 0;
  int hold_seen    = 0;
  int hold_count   = 0;
  int run_left     = 0;
  bit run_ready    = 1'b0;

  scale_key_light_colour #(
    .MAX_ROWS     (MAX_ROWS),
    .SCALE_ENTRIES(SCALE_ENTRIES),
    .MAX_COURSES  (MAX_COURSES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // entry count of a scale word, saturated
  function automatic int scale_size(logic [63:0] s);
    return (s[3:0] > SCALE_ENTRIES) ? SCALE_ENTRIES : int'(s[3:0]);
  endfunction

  function automatic int entry_at(logic [63:0] s, int k);
    return int'(s[4 + 5*k +: 5]);
  endfunction

  // truncating remainder, no wrap at zero span
  function automatic int wrap_note(int sum);
    if (cur_span == 5'd0) return sum;
    return sum % int'(cur_span);
  endfunction

  function automatic bit in_reference(int note);
    for (int k = 0; k < scale_size(cur_ref); k++)
      if (wrap_note(entry_at(cur_ref, k) + int'(cur_ref_tonic)) == note) return 1'b1;
    return 1'b0;
  endfunction

  // update the running state for one course and queue its key words
  task automatic predict_key_colours(logic [23:0] d, logic first);
    int len, so_step, st_step, so_tot, st_tot, size, pos, note, course_out, base;
    bit no_ref, tonic_key, hit;
    key_word_t w;
    len     = int'(d[5:0]);
    so_step = $signed(d[12:6]);
    st_step = $signed(d[19:13]);
    if (first) begin
      courses_seen   = '0;
      scale_total    = '0;
      semitone_total = '0;
    end
    scale_total    = scale_total + so_step[11:0];
    semitone_total = semitone_total + st_step[11:0];
    so_tot = $signed(scale_total);
    st_tot = $signed(semitone_total);
    course_out = int'(courses_seen) + 1;
    if (course_out > MAX_COURSES) course_out = MAX_COURSES;
    courses_seen = course_out[3:0];
    size = scale_size(cur_play);
    if (size == 0) return;
    if (len > MAX_ROWS) len = MAX_ROWS;
    // a negative start offset walks from position zero
    pos = so_tot % size;
    if (pos < 0) pos = 0;
    base   = $signed(cur_base);
    no_ref = scale_size(cur_ref) == 0;
    for (int row = 0; row < len; row++) begin
      note = wrap_note(entry_at(cur_play, pos) + int'(cur_tonic) + base + st_tot);
      tonic_key = cur_mode[0] &&
                  note == (no_ref ? int'(cur_tonic) : int'(cur_ref_tonic));
      w.colour = COL_OFF;
      if (tonic_key) begin
        w.colour = cur_mode[1] ? COL_ACTIVE : COL_INACTIVE;
      end else if (!no_ref) begin
        hit = in_reference(note);
        if (!cur_mode[1]) w.colour = hit ? COL_ACTIVE : COL_OFF;
        else w.colour = hit ? COL_OFF : COL_INACTIVE;
      end
      w.course = course_out[3:0];
      w.row    = 6'(row + 1);
      w.last   = (row + 1 == len);
      pending_keys = {pending_keys, w};
      pos = (pos + 1 >= size) ? 0 : pos + 1;
    end
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // scoreboard: check output words, track register writes, predict accepted courses
  always @(posedge clk) begin : scoreboard
    key_word_t due;
    if (!rst_n) begin
      cur_tonic      = RST_PLAYING_TONIC;
      cur_base       = RST_BASE_NOTE;
      cur_span       = RST_OCTAVE_SPAN;
      cur_ref_tonic  = RST_REF_TONIC;
      cur_mode       = RST_LIGHT_MODE;
      cur_play       = RST_PLAYING_SCALE;
      cur_ref        = RST_REF_SCALE;
      courses_seen   = '0;
      scale_total    = '0;
      semitone_total = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        words_checked++;
        if (pending_keys.size() == 0) begin
          $display("%0t: unexpected key word, expected none actual %h last %b",
                   $time, out_tdata, out_tlast);
          mismatches++;
        end else begin
          due = pending_keys.pop_front();
          compare_field("course_number", due.course, out_tdata[3:0]);
          compare_field("row_number", due.row, out_tdata[9:4]);
          compare_field("colour", due.colour, out_tdata[11:10]);
          compare_field("last_in_course", due.last, out_tlast);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PLAYING_TONIC:   cur_tonic     = cfg_data[3:0];
          REG_BASE_NOTE:       cur_base      = cfg_data[5:0];
          REG_OCTAVE_SPAN:     cur_span      = cfg_data[4:0];
          REG_REF_TONIC:       cur_ref_tonic = cfg_data[4:0];
          REG_LIGHT_MODE:      cur_mode      = cfg_data[1:0];
          REG_PLAYING_SCALE:   cur_play      = cfg_data;
          REG_REFERENCE_SCALE: cur_ref       = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        courses_accepted++;
        predict_key_colours(in_tdata, in_tuser);
      end
    end
  end

  // receiver: alternating ready and stall runs, plus requested long hold-offs
  always @(posedge clk) begin : receiver
    if (hold_serial != hold_seen) begin
      hold_seen  = hold_serial;
      hold_count = hold_request;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_tready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_ready = !run_ready;
        if (run_ready)
          run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 30);
        else
          run_left = $urandom_range(1, 6);
      end
      run_left--;
      out_tready <= run_ready;
    end
  end

  // offer one course word, leave valid high unless a gap follows
  task automatic send_course(int len, int so_step, int st_step, bit first);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, st_step[6:0], so_step[6:0], len[5:0]};
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  // stop offering, wait for every key word, then let a course with no words finish
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, valid left high for the next write
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // random bits above a narrow register field
  function automatic logic [63:0] with_junk(logic [63:0] v, int w);
    return ({$urandom(), $urandom()} << w) | v;
  endfunction

  task automatic load_config(light_setup_t s);
    write_reg(REG_PLAYING_TONIC, with_junk(64'(s.tonic), 4));
    write_reg(REG_BASE_NOTE, with_junk(64'(s.base), 6));
    write_reg(REG_OCTAVE_SPAN, with_junk(64'(s.span), 5));
    write_reg(REG_REF_TONIC, with_junk(64'(s.ref_tonic), 5));
    write_reg(REG_LIGHT_MODE, with_junk(64'(s.mode), 2));
    write_reg(REG_PLAYING_SCALE, s.play_scale);
    write_reg(REG_REFERENCE_SCALE, s.ref_scale);
    // must be ignored
    write_reg(REG_UNUSED, {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
    setups_loaded++;
  endtask

  function automatic light_setup_t reset_setup();
    light_setup_t s;
    s.tonic      = RST_PLAYING_TONIC;
    s.base       = RST_BASE_NOTE;
    s.span       = RST_OCTAVE_SPAN;
    s.ref_tonic  = RST_REF_TONIC;
    s.mode       = RST_LIGHT_MODE;
    s.play_scale = RST_PLAYING_SCALE;
    s.ref_scale  = RST_REF_SCALE;
    return s;
  endfunction

  function automatic logic [63:0] random_scale(logic [3:0] count);
    logic [63:0] s;
    s      = {$urandom(), $urandom()};
    s[3:0] = count;
    return s;
  endfunction

  function automatic light_setup_t random_setup();
    light_setup_t s;
    s.tonic     = 4'($urandom());
    s.base      = 6'($urandom());
    if ($urandom_range(0, 7) == 0) s.span = 5'd0;
    else if ($urandom_range(0, 1) == 0) s.span = 5'd12;
    else s.span = 5'($urandom_range(1, 31));
    s.ref_tonic = 5'($urandom());
    s.mode      = 2'($urandom());
    s.play_scale = random_scale(($urandom_range(0, 9) == 0) ? 4'd0
                                                            : 4'($urandom_range(1, 15)));
    s.ref_scale  = random_scale(($urandom_range(0, 3) == 0) ? 4'd0
                                                            : 4'($urandom_range(1, 15)));
    return s;
  endfunction

  function automatic int rand_step();
    return int'($urandom_range(0, 127)) - 64;
  endfunction

  // mostly short courses, a few long and over-long ones
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(0, 10);
    if (r < 19) return $urandom_range(11, 32);
    return $urandom_range(33, 63);
  endfunction

  // reset registers: length and step extremes, counter saturation
  task automatic test_reset_defaults();
    send_course(1, 0, 0, 1'b1);
    send_course(0, 5, 3, 1'b0);
    send_course(32, 63, 63, 1'b0);
    send_course(63, -64, -64, 1'b0);
    send_course(12, -1, 7, 1'b0);
    send_course(7, 13, -12, 1'b0);
    send_course(3, 0, 0, 1'b0);
    send_course(2, 1, 1, 1'b0);
    send_course(1, 2, 2, 1'b0);
    send_course(5, 0, 0, 1'b0);
    settle_block();
  endtask

  // empty playing scale, zero span with over-full counts and negative offsets
  task automatic test_special_cases();
    light_setup_t s;
    s = reset_setup();
    s.play_scale[3:0] = 4'd0;
    load_config(s);
    send_course(10, 3, 4, 1'b1);
    send_course(5, -2, 1, 1'b0);
    settle_block();
    s = reset_setup();
    s.span       = 5'd0;
    s.base       = 6'b100000;
    s.mode       = 2'd3;
    s.play_scale = random_scale(4'd15);
    s.ref_scale  = random_scale(4'd5);
    load_config(s);
    send_course(20, -30, -50, 1'b1);
    send_course(9, 40, 60, 1'b0);
    settle_block();
  endtask

  // register values at their limits
  task automatic test_register_extremes();
    light_setup_t s;
    for (int k = 0; k < 3; k++) begin
      s = reset_setup();
      case (k)
        0: begin
          s.tonic      = 4'd15;
          s.base       = 6'b100000;
          s.span       = 5'd31;
          s.ref_tonic  = 5'd31;
          s.mode       = 2'd3;
          s.play_scale = '1;
          s.ref_scale  = '1;
        end
        1: begin
          s.base       = 6'd31;
          s.span       = 5'd1;
          s.mode       = 2'd0;
          s.play_scale = 64'd1;
          s.ref_scale  = random_scale(4'd12);
        end
        default: begin
          s.tonic     = 4'd12;
          s.base      = 6'b100000;
          s.span      = 5'd31;
          s.mode      = 2'd2;
          s.ref_scale = random_scale(4'd1);
        end
      endcase
      load_config(s);
      send_course(32, 63, 63, 1'b1);
      send_course(1, -64, -64, 1'b0);
      send_course(63, rand_step(), rand_step(), 1'b0);
      settle_block();
    end
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_config(random_setup());
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_course(pick_length(), rand_step(), rand_step(), $urandom_range(0, 9) == 0);
      settle_block();
    end
  endtask

  // receiver holds off while courses keep coming, so the input backs up
  task automatic test_stall_pressure();
    light_setup_t s;
    s = random_setup();
    s.play_scale[3:0] = 4'd7;
    load_config(s);
    hold_request = 500;
    hold_serial++;
    for (int i = 0; i < 12; i++)
      send_course($urandom_range(4, 12), rand_step(), rand_step(), i == 0);
    settle_block();
  endtask

  // large steps in one direction then the other, so both totals wrap
  task automatic test_offset_wrap();
    light_setup_t s;
    s = random_setup();
    if (s.play_scale[3:0] == 4'd0) s.play_scale[3:0] = 4'd7;
    load_config(s);
    for (int i = 0; i < 45; i++)
      send_course($urandom_range(0, 2), $urandom_range(40, 63), $urandom_range(40, 63), i == 0);
    for (int i = 0; i < 45; i++)
      send_course($urandom_range(0, 2), 0 - int'($urandom_range(40, 64)),
                  0 - int'($urandom_range(40, 64)), 1'b0);
    settle_block();
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_special_cases();
    test_register_extremes();
    test_random_phases();
    test_stall_pressure();
    test_offset_wrap();
    $display("covered %0d courses and %0d key words under %0d register setups",
             courses_accepted, words_checked, setups_loaded);
    $display("including empty scales, zero span, saturation, offset wrap and a long stall");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #RUN_LIMIT;
    $display("timeout with %0d key words still expected", pending_keys.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/skcl_pkg.sv
hdl/skcl_rem_unit.sv
hdl/skcl_colour.sv
hdl/scale_key_light_colour.sv
tb/sv/testbench.sv
